[hw/rtl/tdpg_pkg.sv]
// shared types, widths and helper functions of the trial division prime generator
package tdpg_pkg;

  localparam int PRIME_BITS = 20;
  localparam int COUNT_BITS = 16;
  localparam int STAT_BITS  = 5;
  localparam int CAND_BITS  = PRIME_BITS + 1;
  localparam int SQ_BITS    = CAND_BITS + 1;
  localparam int STEP_BITS  = $clog2(CAND_BITS);
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  localparam int FIRST_PRIME = 2;
  localparam int FIRST_INDEX = 1;

  localparam logic [APB_ADDR_BITS-1:0] REG_PRIME_COUNT = '0;
  localparam logic [COUNT_BITS-1:0] PRIME_COUNT_RESET = COUNT_BITS'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAND,
    ST_TEST,
    ST_DIV,
    ST_CHECK,
    ST_FINISH
  } state_t;

  function automatic logic [STAT_BITS-1:0] count_ones(input logic [PRIME_BITS-1:0] v);
    logic [STAT_BITS-1:0] n;
    n = '0;
    for (int i = 0; i < PRIME_BITS; i++) begin
      n = n + STAT_BITS'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [STAT_BITS-1:0] bit_len(input logic [PRIME_BITS-1:0] v);
    logic [STAT_BITS-1:0] n;
    n = '0;
    for (int i = 0; i < PRIME_BITS; i++) begin
      if (v[i]) begin
        n = STAT_BITS'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

[hw/rtl/tdpg_if.sv]
// request and result channel interfaces
interface tdpg_req_if;
  logic valid;
  logic ready;
  logic next_request;

  modport source (output valid, output next_request, input ready);
  modport sink (input valid, input next_request, output ready);
endinterface

interface tdpg_res_if import tdpg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PRIME_BITS-1:0] prime_value;
  logic [COUNT_BITS-1:0] prime_index;
  logic [STAT_BITS-1:0]  ones_count;
  logic [STAT_BITS-1:0]  bit_length;
  logic                  last;

  modport source (output valid, output prime_value, output prime_index,
                  output ones_count, output bit_length, output last, input ready);
  modport sink (input valid, input prime_value, input prime_index,
                input ones_count, input bit_length, input last, output ready);
endinterface

[hw/rtl/trial_division_prime_generator_top.sv]
// trial division prime generator with apb configuration
// the first prime of a sequence goes from the request straight to ST_FINISH; otherwise each candidate passes
//   ST_CAND, then per trial divisor up to its root ST_TEST, the bit-serial ST_DIV steps and ST_CHECK
// one shared bit-serial remainder unit sets the rate; one request in flight at a time
// a result waits in the output register while the next request is taken
// rst (synchronous) clears the sequence and the output valid, and sets prime_count to 2
module trial_division_prime_generator_top import tdpg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  tdpg_req_if.sink                 req,
  tdpg_res_if.source               res,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  state_t state, state_next;

  logic [COUNT_BITS-1:0] prime_count;
  logic [PRIME_BITS-1:0] last_prime;
  logic [COUNT_BITS-1:0] emitted_count;
  logic [CAND_BITS-1:0]  cand;
  logic [CAND_BITS-1:0]  divisor;
  logic [SQ_BITS-1:0]    square;
  logic [CAND_BITS-1:0]  rem;
  logic [CAND_BITS-1:0]  dividend;
  logic [STEP_BITS-1:0]  step;
  logic [PRIME_BITS-1:0] found_prime;
  logic [COUNT_BITS-1:0] found_index;
  logic                  out_valid;

  logic [CAND_BITS:0]    trial;
  logic                  take_req;
  logic                  out_free;
  logic                  found_last;
  logic                  cfg_write;

  // apb register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == REG_PRIME_COUNT);
  assign prdata    = (paddr == REG_PRIME_COUNT) ? APB_DATA_BITS'(prime_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_count <= PRIME_COUNT_RESET;
    end else if (cfg_write) begin
      prime_count <= pwdata[COUNT_BITS-1:0];
    end
  end

  assign req.ready  = (state == ST_IDLE);
  assign take_req   = req.valid && req.ready;
  assign out_free   = !out_valid || res.ready;
  assign found_last = (found_index == prime_count) || (found_index == {COUNT_BITS{1'b1}});
  assign trial      = {rem, dividend[CAND_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take_req && req.next_request) begin
          state_next = (last_prime == '0) ? ST_FINISH : ST_CAND;
        end
      end
      ST_CAND: begin
        state_next = cand[CAND_BITS-1] ? ST_FINISH : ST_TEST;
      end
      ST_TEST: begin
        state_next = (square > SQ_BITS'(cand)) ? ST_FINISH : ST_DIV;
      end
      ST_DIV: begin
        if (step == STEP_BITS'(CAND_BITS - 1)) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = (rem == '0) ? ST_CAND : ST_TEST;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_prime    <= '0;
      emitted_count <= '0;
    end else if (state == ST_FINISH && out_free) begin
      if (found_last) begin
        last_prime    <= '0;
        emitted_count <= '0;
      end else begin
        last_prime    <= found_prime;
        emitted_count <= found_index;
      end
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cand        <= CAND_BITS'(last_prime) + CAND_BITS'(1);
        found_prime <= PRIME_BITS'(FIRST_PRIME);
        found_index <= COUNT_BITS'(FIRST_INDEX);
      end
      ST_CAND: begin
        divisor     <= CAND_BITS'(FIRST_PRIME);
        square      <= SQ_BITS'(FIRST_PRIME * FIRST_PRIME);
        found_prime <= PRIME_BITS'(FIRST_PRIME);
        found_index <= COUNT_BITS'(FIRST_INDEX);
      end
      ST_TEST: begin
        rem         <= '0;
        dividend    <= cand;
        step        <= '0;
        found_prime <= cand[PRIME_BITS-1:0];
        found_index <= emitted_count + COUNT_BITS'(1);
      end
      ST_DIV: begin
        if (trial >= (CAND_BITS + 1)'(divisor)) begin
          rem <= CAND_BITS'(trial - (CAND_BITS + 1)'(divisor));
        end else begin
          rem <= trial[CAND_BITS-1:0];
        end
        dividend <= {dividend[CAND_BITS-2:0], 1'b0};
        step     <= step + STEP_BITS'(1);
      end
      ST_CHECK: begin
        if (rem == '0) begin
          cand <= cand + CAND_BITS'(1);
        end else begin
          divisor <= divisor + CAND_BITS'(1);
          square  <= square + {divisor, 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      res.prime_value <= found_prime;
      res.prime_index <= found_index;
      res.ones_count  <= count_ones(found_prime);
      res.bit_length  <= bit_len(found_prime);
      res.last        <= found_last;
    end
  end

  assign res.valid = out_valid;

endmodule

[hw/rtl/tdpg_checker.sv]
// port-level checks of the prime generator and their bind
module tdpg_checker import tdpg_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  res_valid,
  input logic                  res_ready,
  input logic [PRIME_BITS-1:0] prime_value,
  input logic [COUNT_BITS-1:0] prime_index,
  input logic [STAT_BITS-1:0]  bit_length
);

  // stalled transaction holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(prime_value) && $stable(prime_index))
    else $error("result changed while stalled");

  a_first_is_two: assert property (@(posedge clk) disable iff (rst)
    res_valid && prime_index == COUNT_BITS'(FIRST_INDEX) |->
      prime_value == PRIME_BITS'(FIRST_PRIME))
    else $error("first prime of a sequence is not two");

  a_odd_prime: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> prime_value[0] || prime_value == PRIME_BITS'(FIRST_PRIME))
    else $error("even prime other than two");

  a_bit_length: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> bit_length != '0 && (prime_value >> (bit_length - STAT_BITS'(1))) == 1)
    else $error("bit length does not match prime");

endmodule

bind trial_division_prime_generator_top tdpg_checker u_tdpg_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .prime_value (res.prime_value),
  .prime_index (res.prime_index),
  .bit_length  (res.bit_length)
);
